FILE: sv/pcdl_pkg.sv
// Package: shared types, codes and helper functions of the pulse credit unit.
`default_nettype none

package pcdl_pkg;

   localparam int CREDIT_W  = 8;
   localparam int IDLE_W    = 16;
   localparam int PULSE_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 16;

   localparam logic [IDLE_W-1:0]   IDLE_LIMIT_RESET  = 16'd60000;
   localparam logic [PULSE_W-1:0]  PULSE_TICKS_RESET = 8'd99;
   localparam logic [CREDIT_W-1:0] CREDIT_MAX        = 8'd255;
   localparam logic [IDLE_W-1:0]   IDLE_MAX          = 16'hFFFF;

   localparam logic [CREDIT_W-1:0] VALUE_TEN  = 8'd10;
   localparam logic [CREDIT_W-1:0] VALUE_FIVE = 8'd5;
   localparam logic [CREDIT_W-1:0] VALUE_TWO  = 8'd2;
   localparam logic [CREDIT_W-1:0] VALUE_ONE  = 8'd1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_TICKS = 1'b1;

   // payout round stage, one-hot
   typedef enum logic [4:0] {
      STAGE_IDLE = 5'b00001,
      STAGE_TEN  = 5'b00010,
      STAGE_FIVE = 5'b00100,
      STAGE_TWO  = 5'b01000,
      STAGE_ONE  = 5'b10000
   } stage_type;

   // block state carried from tick to tick
   typedef struct packed {
      logic                edge_armed;
      logic [CREDIT_W-1:0] credit;
      logic [IDLE_W-1:0]   idle;
      stage_type           stage;
      logic                low_half;
      logic [PULSE_W-1:0]  count;
   } state_type;

   // one result transaction
   typedef struct packed {
      logic                paying_out;
      logic [CREDIT_W-1:0] credit_held;
      logic                out_one;
      logic                out_two;
      logic                out_five;
      logic                out_ten;
   } result_type;

   // credit value of a stage
   function automatic logic [CREDIT_W-1:0] stage_value(input stage_type stage);
      logic [CREDIT_W-1:0] v;
      unique case (stage)
         STAGE_TEN:  v = VALUE_TEN;
         STAGE_FIVE: v = VALUE_FIVE;
         STAGE_TWO:  v = VALUE_TWO;
         STAGE_ONE:  v = VALUE_ONE;
         default:    v = '0;
      endcase
      return v;
   endfunction

   // first stage after 'from' whose value fits the credit, else idle
   function automatic stage_type next_stage(input stage_type from,
                                            input logic [CREDIT_W-1:0] credit);
      logic after_idle;
      logic after_ten;
      logic after_five;
      logic after_two;
      stage_type s;
      after_idle = (from == STAGE_IDLE);
      after_ten  = after_idle || (from == STAGE_TEN);
      after_five = after_ten || (from == STAGE_FIVE);
      after_two  = after_five || (from == STAGE_TWO);
      priority if (after_idle && credit >= VALUE_TEN) s = STAGE_TEN;
      else if (after_ten && credit >= VALUE_FIVE)     s = STAGE_FIVE;
      else if (after_five && credit >= VALUE_TWO)     s = STAGE_TWO;
      else if (after_two && credit >= VALUE_ONE)      s = STAGE_ONE;
      else                                            s = STAGE_IDLE;
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: sv/pcdl_step.sv
// Per-tick next-state and result logic of the pulse credit unit.
`default_nettype none

module pcdl_step
   import pcdl_pkg::*;
(
   input  state_type           state,
   input  logic                line_sample,
   input  logic                line_recheck,
   input  logic [IDLE_W-1:0]   idle_limit,
   input  logic [PULSE_W-1:0]  pulse_ticks,
   output state_type           state_next,
   output result_type          result
);

   logic                edge_armed_s;
   logic [CREDIT_W-1:0] credit_s;
   logic [IDLE_W-1:0]   idle_s;
   logic [IDLE_W-1:0]   idle_inc;
   logic [PULSE_W-1:0]  count_inc;
   logic [CREDIT_W-1:0] value;
   logic [CREDIT_W-1:0] credit_sub;
   logic                line_high;

   // confirmed edge detection, saturating credit
   always_comb begin
      edge_armed_s = state.edge_armed;
      credit_s     = state.credit;
      idle_s       = state.idle;
      if (!line_sample && !line_recheck && state.edge_armed) begin
         if (state.credit != CREDIT_MAX) credit_s = state.credit + 1'b1;
         edge_armed_s = 1'b0;
         idle_s       = '0;
      end else if (line_sample && line_recheck && !state.edge_armed) begin
         edge_armed_s = 1'b1;
      end
   end

   assign idle_inc   = (idle_s == IDLE_MAX) ? idle_s : idle_s + 1'b1;
   assign count_inc  = state.count + 1'b1;
   assign value      = stage_value(state.stage);
   assign credit_sub = (credit_s >= value) ? credit_s - value : '0;
   assign line_high  = (state.stage != STAGE_IDLE) && !state.low_half;

   // idle counting and payout sequencing
   always_comb begin
      state_next            = state;
      state_next.edge_armed = edge_armed_s;
      state_next.credit     = credit_s;
      state_next.idle       = idle_s;
      if (state.stage == STAGE_IDLE) begin
         if (credit_s != '0) begin
            state_next.idle = idle_inc;
            if (idle_inc >= idle_limit) begin
               state_next.idle     = '0;
               state_next.low_half = 1'b0;
               state_next.count    = '0;
               state_next.stage    = next_stage(STAGE_IDLE, credit_s);
            end
         end
      end else begin
         state_next.count = count_inc;
         if (count_inc >= pulse_ticks) begin
            state_next.count = '0;
            if (!state.low_half) begin
               state_next.low_half = 1'b1;
            end else begin
               state_next.low_half = 1'b0;
               state_next.credit   = credit_sub;
               state_next.stage    = next_stage(state.stage, credit_sub);
            end
         end
      end
   end

   // output lines follow the stage entered at the start of the tick
   assign result.out_ten     = line_high && (state.stage == STAGE_TEN);
   assign result.out_five    = line_high && (state.stage == STAGE_FIVE);
   assign result.out_two     = line_high && (state.stage == STAGE_TWO);
   assign result.out_one     = line_high && (state.stage == STAGE_ONE);
   assign result.credit_held = state_next.credit;
   assign result.paying_out  = (state_next.stage != STAGE_IDLE);

endmodule

`default_nettype wire

FILE: sv/pulse_credit_to_denomination_lines_unit.sv
// A request passes the input register, then the result register, before its response.
// Throughput: one transaction per cycle unless stalled; state update is one pcdl_step pass.
// A stalled response holds both registers; with the input register full, req_tready drops.
// Reset: synchronous, active high; clears valid flags and block state and
// loads idle_limit 60000 and pulse_ticks 99.
`default_nettype none

module pulse_credit_to_denomination_lines_unit
   import pcdl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata: [0] line_sample, [1] line_recheck, [7:2] zero
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   // rsp_tdata: [0] out_ten, [1] out_five, [2] out_two, [3] out_one,
   // [11:4] credit_held, [12] paying_out, [15:13] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   logic [IDLE_W-1:0]  idle_limit_ff;
   logic [PULSE_W-1:0] pulse_ticks_ff;
   state_type          state_ff;
   state_type          state_in;
   result_type         result_in;
   result_type         result_ff;
   logic               in_valid_ff;
   logic               sample_ff;
   logic               recheck_ff;
   logic               out_ready;
   logic               in_ready;
   logic               advance;

   // pipeline handshake
   assign out_ready  = !rsp_tvalid || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff  <= IDLE_LIMIT_RESET;
         pulse_ticks_ff <= PULSE_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_LIMIT:  idle_limit_ff  <= csr_data[IDLE_W-1:0];
            CSR_PULSE_TICKS: pulse_ticks_ff <= csr_data[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         sample_ff  <= req_tdata[0];
         recheck_ff <= req_tdata[1];
      end
   end

   pcdl_step u_step (
      .state        (state_ff),
      .line_sample  (sample_ff),
      .line_recheck (recheck_ff),
      .idle_limit   (idle_limit_ff),
      .pulse_ticks  (pulse_ticks_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   // block state moves one tick per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.edge_armed <= 1'b0;
         state_ff.credit     <= '0;
         state_ff.idle       <= '0;
         state_ff.stage      <= STAGE_IDLE;
         state_ff.low_half   <= 1'b0;
         state_ff.count      <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (out_ready) begin
         rsp_tvalid <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tdata = {{(RSP_W - $bits(result_type)){1'b0}}, result_ff};

`ifndef ASSERT_OFF
   // the shown credit is the credit the block now holds
   a_credit_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result_ff.credit_held == state_ff.credit))
      else $error("response credit differs from held credit");

   // at most one denomination line high at a time
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({result_ff.out_ten, result_ff.out_five,
                               result_ff.out_two, result_ff.out_one}))
      else $error("more than one output line high");

   // a line is high only while a payout round runs on the current tick
   a_line_in_round: assert property (@(posedge clock) disable iff (reset)
      advance && (result_in.out_ten || result_in.out_five ||
                  result_in.out_two || result_in.out_one)
      |-> (state_ff.stage != STAGE_IDLE))
      else $error("output line high outside a payout round");
`endif

endmodule

`default_nettype wire
